FILE: rtl/ibdsw_pkg.sv
// Shared constants and types for the serial frame receiver with switch detection.
package ibdsw_pkg;

  // Header pair that opens every frame.
  localparam logic [7:0] HDR_FIRST  = 8'h20;
  localparam logic [7:0] HDR_SECOND = 8'h40;

  // Value reported when the watched channel setting is out of range.
  localparam logic [15:0] INVALID_VALUE = 16'd1500;

  // Number of channels carried in a frame.
  localparam int CHANNEL_COUNT = 14;

  // Default frame length in bytes, header included.
  localparam int FRAME_BYTES_DEF = 32;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int CH_W    = 4;
  localparam int VAL_W   = 16;
  localparam int ACT_W   = 2;
  localparam int CADDR_W = 2;
  localparam int CDATA_W = 16;
  localparam int OUT_TDATA_W = 24;

  // Register reset values.
  localparam logic [CH_W-1:0]  WATCHED_RST = 4'd5;
  localparam logic [VAL_W-1:0] UP_RST      = 16'd1000;
  localparam logic [VAL_W-1:0] DOWN_RST    = 16'd2000;

  // Configuration register indexes.
  typedef enum logic [CADDR_W-1:0] {
    CFG_WATCHED = 2'd0,
    CFG_UP      = 2'd1,
    CFG_DOWN    = 2'd2
  } cfg_idx_t;

  // Switch action codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } action_t;

  // One result word.
  typedef struct packed {
    action_t          action;
    logic             changed;
    logic [VAL_W-1:0] channel_value;
  } result_t;

endpackage

FILE: rtl/ibus_deframer_switch_detect_top.sv
// Top level of the serial frame receiver: header hunt, channel capture and switch detection.
//
//   Channel   Ports                       Word contents (lowest bit up)
//   input     in_tvalid/tready/tdata      rx_byte[7:0]
//   result    out_tvalid/tready/tdata     channel_value[15:0], changed[16], action[18:17]
//   config    cfg_wr_en/addr/wdata        index 0 watched channel, 1 up value, 2 down value
//
// One byte is accepted per cycle while in_tready is high. Each byte updates the frame state
// in the same cycle, and the last byte of a clean frame writes its result into a two-word
// output buffer, whose main register drives out_tvalid and out_tdata.
// The reset is synchronous and active low; it restores the register defaults and restarts
// the header hunt. When the sink stalls, one result waits in the output register and a
// second one in the skid register; in_tready drops only while the skid register is full.
module ibus_deframer_switch_detect_top
  import ibdsw_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // rx_byte[7:0]
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // channel_value[15:0], changed[16],
                                             // action[18:17], zeros[23:19]
  // Configuration write port.
  input  logic                   cfg_wr_en,
  input  logic [CADDR_W-1:0]     cfg_addr,
  input  logic [CDATA_W-1:0]     cfg_wdata
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int CMP_W = 7;

  // Configuration registers.
  logic [CH_W-1:0]  watched_r;
  logic [VAL_W-1:0] up_r;
  logic [VAL_W-1:0] down_r;

  // Frame state.
  logic              hunt_r, hunt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] prev_r;
  logic              emb_r, emb_nxt;
  logic [VAL_W-1:0]  cap_r, cap_nxt;
  logic [VAL_W-1:0]  last_r, last_nxt;

  // Output buffer: main register and skid register.
  logic    main_vld_r, skid_vld_r;
  result_t main_r, skid_r;

  logic       in_fire, out_fire;
  logic       res_push;
  result_t    res;
  logic       ch_ok;
  logic [CMP_W-1:0] pos_ext, lo_pos;
  logic [VAL_W-1:0] val;

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = main_vld_r;
  assign out_fire  = main_vld_r && out_tready;
  assign out_tdata = OUT_TDATA_W'(main_r);

  // Channel c occupies frame bytes 2c (low) and 2c+1 (high).
  assign ch_ok   = (watched_r != '0) && (int'(watched_r) <= CHANNEL_COUNT);
  assign pos_ext = CMP_W'(pos_r);
  assign lo_pos  = CMP_W'({watched_r, 1'b0});

  always_comb begin
    hunt_nxt = hunt_r;
    pos_nxt  = pos_r;
    emb_nxt  = emb_r;
    cap_nxt  = cap_r;
    last_nxt = last_r;
    res_push = 1'b0;
    val      = cap_r;
    res      = '{action: ACT_NONE, changed: 1'b0, channel_value: cap_r};
    if (hunt_r) begin
      if (pos_r == POS_W'(1) && in_tdata == HDR_SECOND) begin
        pos_nxt  = POS_W'(2);
        hunt_nxt = 1'b0;
        emb_nxt  = 1'b0;
        cap_nxt  = '0;
      end else if (in_tdata == HDR_FIRST) begin
        pos_nxt = POS_W'(1);
      end else begin
        pos_nxt = '0;
      end
    end else begin
      // A header pair starting at byte 2 or later spoils the frame.
      if (pos_r >= POS_W'(3) && prev_r == HDR_FIRST && in_tdata == HDR_SECOND) begin
        emb_nxt = 1'b1;
      end
      if (ch_ok) begin
        if (pos_ext == lo_pos) begin
          cap_nxt[7:0] = in_tdata;
        end else if (pos_ext == lo_pos + CMP_W'(1)) begin
          cap_nxt[15:8] = in_tdata;
        end
      end
      if (pos_r == POS_W'(FRAME_BYTES - 1)) begin
        hunt_nxt = 1'b1;
        pos_nxt  = '0;
        val      = ch_ok ? cap_nxt : INVALID_VALUE;
        res.channel_value = val;
        if (!emb_nxt) begin
          res_push = 1'b1;
          if (last_r != '0 && val != last_r) begin
            res.changed = 1'b1;
            if (val == up_r) begin
              res.action = ACT_UP;
            end else if (val == down_r) begin
              res.action = ACT_DOWN;
            end
          end
          last_nxt = val;
        end
        emb_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watched_r <= WATCHED_RST;
      up_r      <= UP_RST;
      down_r    <= DOWN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_WATCHED: watched_r <= cfg_wdata[CH_W-1:0];
        CFG_UP:      up_r      <= cfg_wdata;
        CFG_DOWN:    down_r    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Frame state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r <= 1'b1;
      pos_r  <= '0;
      prev_r <= '0;
      emb_r  <= 1'b0;
      cap_r  <= '0;
      last_r <= '0;
    end else if (in_fire) begin
      hunt_r <= hunt_nxt;
      pos_r  <= pos_nxt;
      prev_r <= in_tdata;
      emb_r  <= emb_nxt;
      cap_r  <= cap_nxt;
      last_r <= last_nxt;
    end
  end

  // Two-word output buffer.
  logic push;
  assign push = in_fire && res_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_fire) begin
          skid_vld_r <= 1'b0;
        end
      end else if (push && main_vld_r && !out_fire) begin
        skid_vld_r <= 1'b1;
      end
      if (!main_vld_r) begin
        main_vld_r <= push;
      end else if (out_fire) begin
        main_vld_r <= skid_vld_r || push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_fire) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_vld_r || out_fire) begin
        main_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  // The skid register only holds a word behind a waiting main word.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid word without main word");

  // A result only comes from a byte inside a frame.
  a_push_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !hunt_r)
    else $error("result pushed while hunting for a header");

  // After a result the receiver hunts again.
  a_hunt_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> hunt_r && pos_r == '0)
    else $error("hunt not restarted after a result");

  // An action is only reported together with a change.
  a_action_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && main_r.action != ACT_NONE) |-> main_r.changed)
    else $error("action reported without change");

  // The byte position stays inside the frame.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) < FRAME_BYTES)
    else $error("byte position beyond frame end");

endmodule
